[hdl/bfd_pkg.sv]
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared constants and types for the biosignal frame deframer.
// ----------------------------------------------------------------------------
package bfd_pkg;

    localparam int CHANNELS_DEF = 8;

    localparam logic [7:0] HDR_BYTE  = 8'hFF;
    localparam logic [7:0] CMD_REPLY = 8'h03;
    localparam logic [7:0] CMD_DATA  = 8'h01;

    // result kinds
    localparam logic [1:0] KIND_SAMPLE   = 2'd0;
    localparam logic [1:0] KIND_REPLY_OK = 2'd1;
    localparam logic [1:0] KIND_REPLY_ERR = 2'd2;

    typedef logic signed [23:0] sample_t;

    // burst request from parser to result sequencer
    typedef struct packed {
        logic       load;
        logic       is_data;
        logic [1:0] kind;
        logic [7:0] reply_value;
        logic       sum_ok;
    } event_t;

endpackage

[hdl/bfd_parser.sv]
// ----------------------------------------------------------------------------
// bfd_parser
// Byte-level frame parser: header hunt, command decode, sample assembly.
// ----------------------------------------------------------------------------
module bfd_parser #(
    parameter int CHANNELS = bfd_pkg::CHANNELS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_rx_byte,
    input  logic            burst_free,
    output bfd_pkg::event_t ev,
    output bfd_pkg::sample_t store [CHANNELS]
);
    import bfd_pkg::*;

    localparam int DATA_FIRST = 6;
    localparam int DATA_END   = DATA_FIRST + 3 * CHANNELS;
    localparam int POS_W      = $clog2(DATA_END + 1);
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [2:0] PH_HUNT1 = 3'd0;
    localparam logic [2:0] PH_HUNT2 = 3'd1;
    localparam logic [2:0] PH_CMD   = 3'd2;
    localparam logic [2:0] PH_REPLY = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;

    localparam logic [POS_W-1:0] POS_VALUE = POS_W'(3);
    localparam logic [POS_W-1:0] POS_ECHO  = POS_W'(4);

    logic [2:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       held_reg, held_next;
    logic [15:0]      partial_reg, partial_next;
    logic [1:0]       sub_reg, sub_next;
    logic [CH_W-1:0]  ch_reg, ch_next;
    logic             wr_en;
    logic             emit_state;
    logic             accept;

    // results are only raised at the echo byte or the checksum byte
    assign emit_state = ((phase_reg == PH_REPLY) && (pos_reg != POS_VALUE)) ||
                        ((phase_reg == PH_DATA) && (pos_reg == POS_W'(DATA_END)));
    assign s_ready = !emit_state || burst_free;
    assign accept  = s_valid && s_ready;

    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        held_next    = held_reg;
        partial_next = partial_reg;
        sub_next     = sub_reg;
        ch_next      = ch_reg;
        wr_en        = 1'b0;
        ev           = '0;
        if (accept) begin
            case (phase_reg)
                PH_HUNT2: begin
                    phase_next = (s_rx_byte == HDR_BYTE) ? PH_CMD : PH_HUNT1;
                end
                PH_CMD: begin
                    pos_next = POS_VALUE;
                    if (s_rx_byte == CMD_REPLY) begin
                        phase_next = PH_REPLY;
                    end else if (s_rx_byte == CMD_DATA) begin
                        phase_next   = PH_DATA;
                        sum_next     = '0;
                        partial_next = '0;
                        sub_next     = '0;
                        ch_next      = '0;
                    end else begin
                        // 0xFF here pairs with the previous 0xFF as a new header
                        phase_next = (s_rx_byte == HDR_BYTE) ? PH_CMD : PH_HUNT1;
                    end
                end
                PH_REPLY: begin
                    if (pos_reg == POS_VALUE) begin
                        held_next = s_rx_byte;
                        pos_next  = POS_ECHO;
                    end else begin
                        ev.load        = 1'b1;
                        ev.is_data     = 1'b0;
                        ev.kind        = (s_rx_byte == held_reg) ? KIND_REPLY_OK
                                                                 : KIND_REPLY_ERR;
                        ev.reply_value = held_reg;
                        phase_next     = PH_HUNT1;
                        pos_next       = '0;
                    end
                end
                PH_DATA: begin
                    if (pos_reg < POS_W'(DATA_FIRST)) begin
                        pos_next = pos_reg + 1'b1;
                    end else if (pos_reg < POS_W'(DATA_END)) begin
                        sum_next     = sum_reg + s_rx_byte;
                        partial_next = {partial_reg[7:0], s_rx_byte};
                        if (sub_reg == 2'd2) begin
                            wr_en        = 1'b1;
                            partial_next = '0;
                            sub_next     = '0;
                            ch_next      = ch_reg + 1'b1;
                        end else begin
                            sub_next = sub_reg + 1'b1;
                        end
                        pos_next = pos_reg + 1'b1;
                    end else begin
                        // checksum byte
                        ev.load    = 1'b1;
                        ev.is_data = 1'b1;
                        ev.kind    = KIND_SAMPLE;
                        ev.sum_ok  = (sum_reg == s_rx_byte);
                        phase_next = PH_HUNT1;
                        pos_next   = '0;
                        sum_next   = '0;
                    end
                end
                default: begin
                    phase_next = (s_rx_byte == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT1;
            pos_reg     <= '0;
            sum_reg     <= '0;
            held_reg    <= '0;
            partial_reg <= '0;
            sub_reg     <= '0;
            ch_reg      <= '0;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            held_reg    <= held_next;
            partial_reg <= partial_next;
            sub_reg     <= sub_next;
            ch_reg      <= ch_next;
        end
    end

    // sample store, written once per channel within a frame
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[ch_reg] <= {partial_reg, s_rx_byte};
        end
    end

endmodule

[hdl/bfd_emitter.sv]
// ----------------------------------------------------------------------------
// bfd_emitter
// Result register and burst sequencer: one reply or CHANNELS sample beats.
// ----------------------------------------------------------------------------
module bfd_emitter #(
    parameter int CHANNELS = bfd_pkg::CHANNELS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  bfd_pkg::event_t  ev,
    input  bfd_pkg::sample_t store [CHANNELS],
    output logic             burst_free,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_kind,
    output logic [2:0]       m_channel,
    output logic signed [23:0] m_sample,
    output logic [7:0]       m_reply_value,
    output logic             m_sum_ok,
    output logic             m_last
);
    import bfd_pkg::*;

    localparam int CNT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic             active_reg, active_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             is_data_reg;
    logic [1:0]       kind_reg;
    logic [7:0]       value_reg;
    logic             ok_reg;
    sample_t          snap_reg [CHANNELS];
    logic             beat_last;
    logic             fire;
    logic [CNT_W+2:0] cnt_ext;

    assign beat_last  = !is_data_reg || (cnt_reg == CNT_W'(CHANNELS - 1));
    assign fire       = active_reg && m_ready;
    assign burst_free = !active_reg || (m_ready && beat_last);

    always_comb begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        if (ev.load) begin
            active_next = 1'b1;
            cnt_next    = '0;
        end else if (fire) begin
            if (beat_last) begin
                active_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload: snapshot of the store, shifted down one channel per beat
    always_ff @(posedge aclk) begin
        if (ev.load) begin
            is_data_reg <= ev.is_data;
            kind_reg    <= ev.kind;
            value_reg   <= ev.reply_value;
            ok_reg      <= ev.sum_ok;
            for (int i = 0; i < CHANNELS; i++) begin
                snap_reg[i] <= store[i];
            end
        end else if (fire) begin
            for (int i = 0; i < CHANNELS - 1; i++) begin
                snap_reg[i] <= snap_reg[i+1];
            end
        end
    end

    assign cnt_ext       = {3'b000, cnt_reg};
    assign m_valid       = active_reg;
    assign m_kind        = kind_reg;
    assign m_channel     = is_data_reg ? cnt_ext[2:0] : 3'd0;
    assign m_sample      = is_data_reg ? snap_reg[0] : '0;
    assign m_reply_value = is_data_reg ? 8'd0 : value_reg;
    assign m_sum_ok      = is_data_reg && ok_reg;
    assign m_last        = beat_last;

endmodule

[hdl/biosignal_frame_deframer.sv]
// ----------------------------------------------------------------------------
// biosignal_frame_deframer
// Serial byte stream deframer for reply frames and multichannel data frames.
// ----------------------------------------------------------------------------
// Latency: a result is valid the cycle after the byte that causes it.
// Throughput: one byte per cycle; a data frame's CHANNELS results leave one
//   per cycle from the result register while m_ready is high. The echo or
//   checksum byte waits while a burst is held, until its final transfer leaves.
// Reset: synchronous, active low aresetn; parser returns to header hunt,
//   the result register empties. Sample store is not reset.
// ----------------------------------------------------------------------------
module biosignal_frame_deframer #(
    parameter int CHANNELS = bfd_pkg::CHANNELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input byte channel, one transfer per received byte
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    // result channel, one transfer per result
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [2:0]         m_channel,
    output logic signed [23:0] m_sample,
    output logic [7:0]         m_reply_value,
    output logic               m_sum_ok,
    output logic               m_last
);
    import bfd_pkg::*;

    event_t  ev;
    sample_t store [CHANNELS];
    logic    burst_free;

    // Parser: header hunt, command decode, sample assembly and checksum.
    // Raises ev.load on the byte that completes a reply or a data frame.
    bfd_parser #(
        .CHANNELS (CHANNELS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .burst_free (burst_free),
        .ev         (ev),
        .store      (store)
    );

    // Emitter: copies the store at frame end so the next frame can be parsed
    // while the samples drain, then walks the channels one transfer at a time.
    bfd_emitter #(
        .CHANNELS (CHANNELS)
    ) u_emitter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ev            (ev),
        .store         (store),
        .burst_free    (burst_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_channel     (m_channel),
        .m_sample      (m_sample),
        .m_reply_value (m_reply_value),
        .m_sum_ok      (m_sum_ok),
        .m_last        (m_last)
    );

endmodule
